/* hw/rtl/jsu8dec_pkg.sv */
// ----------------------------------------------------------------------------
// jsu8dec_pkg
// Types, constants and helper functions for the JSON string byte decoder.
// ----------------------------------------------------------------------------
package jsu8dec_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 19;
    localparam int unsigned MAX_STRING_BYTES_DEF = 262144;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               is_close;
        logic               terminated;
        logic [COUNT_W-1:0] byte_count;
        logic               last;
    } t_result;

    function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] esc_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        unique case (c)
            CH_LOW_B: v = CH_BS;
            CH_LOW_F: v = CH_FF;
            CH_LOW_N: v = CH_LF;
            CH_LOW_R: v = CH_CR;
            CH_LOW_T: v = CH_TAB;
            default:  v = c;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/jsu8dec_in_if.sv */
// ----------------------------------------------------------------------------
// jsu8dec_in_if
// Raw string byte channel: valid/ready handshake plus byte and end flag.
// ----------------------------------------------------------------------------
interface jsu8dec_in_if;
    logic                           valid;
    logic                           ready;
    logic [jsu8dec_pkg::BYTE_W-1:0] in_byte;
    logic                           buffer_end;

    modport source (output valid, output in_byte, output buffer_end, input ready);
    modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

/* hw/rtl/jsu8dec_out_if.sv */
// ----------------------------------------------------------------------------
// jsu8dec_out_if
// Decoded byte / close channel: valid/ready handshake plus result fields.
// ----------------------------------------------------------------------------
interface jsu8dec_out_if;
    logic                            valid;
    logic                            ready;
    logic [jsu8dec_pkg::BYTE_W-1:0]  out_byte;
    logic                            is_close;
    logic                            terminated;
    logic [jsu8dec_pkg::COUNT_W-1:0] byte_count;
    logic                            last;

    modport source (output valid, output out_byte, output is_close, output terminated,
                    output byte_count, output last, input ready);
    modport sink   (input valid, input out_byte, input is_close, input terminated,
                    input byte_count, input last, output ready);
endinterface

/* hw/rtl/json_string_utf8_byte_decoder.sv */
// ----------------------------------------------------------------------------
// json_string_utf8_byte_decoder
// Unescapes and UTF-8 decodes a JSON string body, one raw byte per cycle while the output keeps up.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : raw bytes following the opening quote, with a buffer_end flag.
//   o_out : per decoded code point one data transaction (low byte), and one
//           close transaction (is_close=1) carrying the emitted byte count.
//           'last' marks the final result produced by one input transaction.
// Each input transaction yields zero to three results (flush of a broken
// UTF-8 sequence, decoded byte, close). Decoding happens in the accept cycle
// and the results land in a three-entry result register; the first result
// is visible in the cycle after acceptance.
// Throughput: one input per cycle while each input yields at most one result
// and the receiver is ready; more results hold the input side until the last
// leaves. The output port (one result per cycle) sets the limit.
// A new input is taken in the same cycle the last pending result leaves, so
// a stalled receiver holds the input side only while results are waiting.
// Reset: decoder returns to plain-character mode, count cleared, no results
// pending. Decoder state also returns to reset after every close.
// ----------------------------------------------------------------------------
module json_string_utf8_byte_decoder #(
    parameter int unsigned MAX_STRING_BYTES = jsu8dec_pkg::MAX_STRING_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jsu8dec_in_if.sink       i_in,
    jsu8dec_out_if.source    o_out
);

    localparam int unsigned BW = jsu8dec_pkg::BYTE_W;
    localparam int unsigned CW = jsu8dec_pkg::COUNT_W;
    localparam logic [CW-1:0] COUNT_CAP =
        (MAX_STRING_BYTES > ((1 << CW) - 1)) ? {CW{1'b1}} : CW'(MAX_STRING_BYTES);

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX,
        MODE_UTF
    } t_mode;

    t_mode               r_mode, n_mode;
    logic [2:0]          r_digits, n_digits;
    logic [BW-1:0]       r_accum, n_accum;
    logic [CW-1:0]       r_count, n_count;

    jsu8dec_pkg::t_result r_res [3];
    jsu8dec_pkg::t_result n_res [3];
    logic [1:0]          r_num, n_num;
    logic [1:0]          r_pos;

    logic                in_fire;
    logic                out_fire;

    assign out_fire = o_out.valid && o_out.ready;
    assign i_in.ready = (r_pos == r_num) || (o_out.ready && (r_pos + 2'd1 == r_num));
    assign in_fire = i_in.valid && i_in.ready;

    always_comb begin
        logic [BW-1:0] c;
        logic          do_plain;
        logic          closed;
        c        = i_in.in_byte;
        do_plain = 1'b0;
        closed   = 1'b0;
        n_mode   = r_mode;
        n_digits = r_digits;
        n_accum  = r_accum;
        n_count  = r_count;
        n_num    = 2'd0;
        for (int i = 0; i < 3; i++) begin
            n_res[i] = '0;
        end

        unique case (r_mode)
            MODE_PLAIN: begin
                do_plain = 1'b1;
            end
            MODE_ESC: begin
                if (c == jsu8dec_pkg::CH_LOW_U) begin
                    n_mode   = MODE_HEX;
                    n_digits = 3'd4;
                    n_accum  = '0;
                end else begin
                    n_mode = MODE_PLAIN;
                    n_res[n_num].out_byte = jsu8dec_pkg::esc_value(c);
                    n_num = n_num + 2'd1;
                    if (n_count < COUNT_CAP) n_count = n_count + 1'b1;
                end
            end
            MODE_HEX: begin
                n_accum = {n_accum[3:0], jsu8dec_pkg::hex_value(c)};
                if (n_digits != 3'd0) n_digits = n_digits - 3'd1;
                if (n_digits == 3'd0) begin
                    n_mode = MODE_PLAIN;
                    n_res[n_num].out_byte = n_accum;
                    n_num = n_num + 2'd1;
                    if (n_count < COUNT_CAP) n_count = n_count + 1'b1;
                    n_accum = '0;
                end
            end
            MODE_UTF: begin
                if (c[7:6] == 2'b10) begin
                    n_accum = {n_accum[1:0], c[5:0]};
                    if (n_digits != 3'd0) n_digits = n_digits - 3'd1;
                    if (n_digits == 3'd0) begin
                        n_mode = MODE_PLAIN;
                        n_res[n_num].out_byte = n_accum;
                        n_num = n_num + 2'd1;
                        if (n_count < COUNT_CAP) n_count = n_count + 1'b1;
                        n_accum = '0;
                    end
                end else begin
                    // broken sequence: flush partial value, then treat as plain
                    n_mode   = MODE_PLAIN;
                    n_digits = 3'd0;
                    n_res[n_num].out_byte = n_accum;
                    n_num = n_num + 2'd1;
                    if (n_count < COUNT_CAP) n_count = n_count + 1'b1;
                    n_accum  = '0;
                    do_plain = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_plain) begin
            if (c == jsu8dec_pkg::CH_QUOTE) begin
                n_res[n_num].is_close   = 1'b1;
                n_res[n_num].terminated = 1'b1;
                n_res[n_num].byte_count = n_count;
                n_num    = n_num + 2'd1;
                closed   = 1'b1;
                n_mode   = MODE_PLAIN;
                n_digits = 3'd0;
                n_accum  = '0;
                n_count  = '0;
            end else if (c == jsu8dec_pkg::CH_BSLASH) begin
                n_mode = MODE_ESC;
            end else if (c[7:5] == 3'b110) begin
                n_accum  = {3'b000, c[4:0]};
                n_digits = 3'd1;
                n_mode   = MODE_UTF;
            end else if (c[7:4] == 4'b1110) begin
                n_accum  = {4'b0000, c[3:0]};
                n_digits = 3'd2;
                n_mode   = MODE_UTF;
            end else if (c[7:3] == 5'b11110) begin
                n_accum  = {5'b00000, c[2:0]};
                n_digits = 3'd3;
                n_mode   = MODE_UTF;
            end else begin
                n_res[n_num].out_byte = c;
                n_num = n_num + 2'd1;
                if (n_count < COUNT_CAP) n_count = n_count + 1'b1;
            end
        end

        if (i_in.buffer_end && !closed) begin
            if (n_mode == MODE_HEX || n_mode == MODE_UTF) begin
                n_res[n_num].out_byte = n_accum;
                n_num = n_num + 2'd1;
                if (n_count < COUNT_CAP) n_count = n_count + 1'b1;
            end
            n_res[n_num].is_close   = 1'b1;
            n_res[n_num].terminated = 1'b0;
            n_res[n_num].byte_count = n_count;
            n_num    = n_num + 2'd1;
            n_mode   = MODE_PLAIN;
            n_digits = 3'd0;
            n_accum  = '0;
            n_count  = '0;
        end

        for (int i = 0; i < 3; i++) begin
            n_res[i].last = (2'(i) + 2'd1 == n_num);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_digits <= 3'd0;
            r_accum  <= '0;
            r_count  <= '0;
            r_num    <= 2'd0;
            r_pos    <= 2'd0;
        end else begin
            if (in_fire) begin
                r_mode   <= n_mode;
                r_digits <= n_digits;
                r_accum  <= n_accum;
                r_count  <= n_count;
                r_num    <= n_num;
                r_pos    <= 2'd0;
            end else if (out_fire) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= n_res[i];
            end
        end
    end

    assign o_out.valid      = (r_pos != r_num);
    assign o_out.out_byte   = r_res[r_pos].out_byte;
    assign o_out.is_close   = r_res[r_pos].is_close;
    assign o_out.terminated = r_res[r_pos].terminated;
    assign o_out.byte_count = r_res[r_pos].byte_count;
    assign o_out.last       = r_res[r_pos].last;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_num)
        else $error("result pointer ran past result count");

    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_close |-> o_out.last)
        else $error("close transaction not marked last");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_close |-> (o_out.byte_count == '0) && !o_out.terminated)
        else $error("data transaction carries close fields");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last |=> o_out.valid)
        else $error("result burst broken before last");

endmodule

/* sim/tb_json_string_utf8_byte_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_utf8_byte_decoder
// Self-checking bench for the JSON string byte decoder. A directed table covers
// the escapes, unicode escapes, UTF-8 runs, broken sequences and both kinds of
// close. Random strings, mostly well formed, follow. An in-bench decoder
// predicts each result and every output transaction is compared in order.
// Both handshakes idle at random, with one long output stall and one drain
// pause on the input side.
// ----------------------------------------------------------------------------
module tb_json_string_utf8_byte_decoder;

    localparam int unsigned STR_CAP = 256;
    localparam logic [jsu8dec_pkg::COUNT_W-1:0] COUNT_LIMIT =
        (STR_CAP > 32'h7FFFF) ? '1 : jsu8dec_pkg::COUNT_W'(STR_CAP);
    localparam int RAND_BYTES = 200;
    localparam int HOLD_CYCLES = 60;

    typedef enum logic [1:0] {DM_PLAIN, DM_ESC, DM_HEX, DM_UTF} t_dec_mode;

    typedef struct packed {
        logic [jsu8dec_pkg::BYTE_W-1:0] b;
        logic                           be;
        logic                           typed;
        jsu8dec_pkg::t_result           res;
    } t_row;

    typedef struct packed {
        logic [jsu8dec_pkg::BYTE_W-1:0] b;
        logic                           be;
    } t_raw;

    logic i_clk;
    logic i_rst_n;

    jsu8dec_in_if  in_ch ();
    jsu8dec_out_if out_ch ();

    json_string_utf8_byte_decoder #(
        .MAX_STRING_BYTES(STR_CAP)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // decoder model state
    t_dec_mode                       dmode;
    logic [2:0]                      digits;
    logic [jsu8dec_pkg::BYTE_W-1:0]  accum;
    logic [jsu8dec_pkg::COUNT_W-1:0] emitted;

    jsu8dec_pkg::t_result decoded_q[$];
    jsu8dec_pkg::t_result step_out[$];
    t_row                 dir_table[$];
    t_raw                 str_q[$];

    logic                 row_typed;
    jsu8dec_pkg::t_result row_res;
    int                   fail_cnt;
    bit                   quiet;
    bit                   hold_req;
    int                   hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("json_string_utf8_byte_decoder test failed");
        $finish;
    end

    function automatic void clear_decoder();
        dmode   = DM_PLAIN;
        digits  = '0;
        accum   = '0;
        emitted = '0;
    endfunction

    function automatic void emit_data(input logic [jsu8dec_pkg::BYTE_W-1:0] v);
        jsu8dec_pkg::t_result r;
        r = '0;
        r.out_byte = v;
        step_out.push_back(r);
        if (emitted < COUNT_LIMIT) emitted++;
    endfunction

    function automatic void emit_close(input logic by_quote);
        jsu8dec_pkg::t_result r;
        r = '0;
        r.is_close   = 1'b1;
        r.terminated = by_quote;
        r.byte_count = emitted;
        step_out.push_back(r);
        clear_decoder();
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [jsu8dec_pkg::BYTE_W-1:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= "0" && c <= "9") d = 4'(c - "0");
        else if (c >= "a" && c <= "f") d = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") d = 4'(c - "A" + 10);
        return d;
    endfunction

    // returns 1 when the byte closed the string
    function automatic logic plain_char(input logic [jsu8dec_pkg::BYTE_W-1:0] c);
        if (c == jsu8dec_pkg::CH_QUOTE) begin
            emit_close(1'b1);
            return 1'b1;
        end
        if (c == jsu8dec_pkg::CH_BSLASH) begin
            dmode = DM_ESC;
        end else if (!c[7]) begin
            emit_data(c);
        end else if (c[7:5] == 3'b110) begin
            accum  = {3'b000, c[4:0]};
            digits = 3'd1;
            dmode  = DM_UTF;
        end else if (c[7:4] == 4'b1110) begin
            accum  = {4'b0000, c[3:0]};
            digits = 3'd2;
            dmode  = DM_UTF;
        end else if (c[7:3] == 5'b11110) begin
            accum  = {5'b00000, c[2:0]};
            digits = 3'd3;
            dmode  = DM_UTF;
        end else begin
            emit_data(c);
        end
        return 1'b0;
    endfunction

    function automatic void decode_byte(input logic [jsu8dec_pkg::BYTE_W-1:0] c,
                                        input logic be);
        logic                           closed;
        logic [jsu8dec_pkg::BYTE_W-1:0] v;
        closed = 1'b0;
        step_out.delete();
        case (dmode)
            DM_PLAIN: begin
                closed = plain_char(c);
            end
            DM_ESC: begin
                if (c == jsu8dec_pkg::CH_LOW_U) begin
                    dmode  = DM_HEX;
                    digits = 3'd4;
                    accum  = '0;
                end else begin
                    case (c)
                        jsu8dec_pkg::CH_LOW_B: v = jsu8dec_pkg::CH_BS;
                        jsu8dec_pkg::CH_LOW_F: v = jsu8dec_pkg::CH_FF;
                        jsu8dec_pkg::CH_LOW_N: v = jsu8dec_pkg::CH_LF;
                        jsu8dec_pkg::CH_LOW_R: v = jsu8dec_pkg::CH_CR;
                        jsu8dec_pkg::CH_LOW_T: v = jsu8dec_pkg::CH_TAB;
                        default:               v = c;
                    endcase
                    dmode = DM_PLAIN;
                    emit_data(v);
                end
            end
            DM_HEX: begin
                accum = {accum[3:0], hex_nibble(c)};
                if (digits != 0) digits--;
                if (digits == 0) begin
                    dmode = DM_PLAIN;
                    emit_data(accum);
                    accum = '0;
                end
            end
            default: begin
                if (c[7:6] == 2'b10) begin
                    accum = {accum[1:0], c[5:0]};
                    if (digits != 0) digits--;
                    if (digits == 0) begin
                        dmode = DM_PLAIN;
                        emit_data(accum);
                        accum = '0;
                    end
                end else begin
                    dmode  = DM_PLAIN;
                    digits = '0;
                    emit_data(accum);
                    accum  = '0;
                    closed = plain_char(c);
                end
            end
        endcase
        if (be && !closed) begin
            if (dmode == DM_HEX || dmode == DM_UTF) emit_data(accum);
            emit_close(1'b0);
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    endfunction

    // checker and predictor
    always @(posedge i_clk) begin
        jsu8dec_pkg::t_result e;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result transaction: out_byte %0h is_close %0b",
                           out_ch.out_byte, out_ch.is_close);
                    fail_cnt++;
                end else begin
                    e = decoded_q.pop_front();
                    if (out_ch.out_byte !== e.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", e.out_byte, out_ch.out_byte);
                        fail_cnt++;
                    end
                    if (out_ch.is_close !== e.is_close) begin
                        $error("is_close: expected %0b, got %0b", e.is_close, out_ch.is_close);
                        fail_cnt++;
                    end
                    if (out_ch.terminated !== e.terminated) begin
                        $error("terminated: expected %0b, got %0b",
                               e.terminated, out_ch.terminated);
                        fail_cnt++;
                    end
                    if (out_ch.byte_count !== e.byte_count) begin
                        $error("byte_count: expected %0d, got %0d",
                               e.byte_count, out_ch.byte_count);
                        fail_cnt++;
                    end
                    if (out_ch.last !== e.last) begin
                        $error("last: expected %0b, got %0b", e.last, out_ch.last);
                        fail_cnt++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.in_byte, in_ch.buffer_end);
                if (row_typed) decoded_q.push_back(row_res);
                else foreach (step_out[k]) decoded_q.push_back(step_out[k]);
            end
        end
    end

    // receiver
    initial begin
        out_ch.ready = 1'b0;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (quiet) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 14);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [jsu8dec_pkg::BYTE_W-1:0] b, input logic be,
                             input logic typed, input jsu8dec_pkg::t_result res);
        if (!quiet && !hold_req && hold_left == 0) begin
            while ($urandom_range(99) < 14) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.buffer_end <= be;
        row_typed        <= typed;
        row_res          <= res;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (decoded_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic jsu8dec_pkg::t_result mk_data(input logic [jsu8dec_pkg::BYTE_W-1:0] v);
        jsu8dec_pkg::t_result r;
        r = '0;
        r.out_byte = v;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic jsu8dec_pkg::t_result mk_close(input logic term,
            input logic [jsu8dec_pkg::COUNT_W-1:0] cnt);
        jsu8dec_pkg::t_result r;
        r = '0;
        r.is_close = 1'b1;
        r.terminated = term;
        r.byte_count = cnt;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void row(input logic [jsu8dec_pkg::BYTE_W-1:0] b, input logic be,
                                input logic typed, input jsu8dec_pkg::t_result res);
        dir_table.push_back('{b, be, typed, res});
    endfunction

    function automatic void raw(input logic [jsu8dec_pkg::BYTE_W-1:0] b);
        str_q.push_back('{b, 1'b0});
    endfunction

    function automatic logic [jsu8dec_pkg::BYTE_W-1:0] hex_char();
        int d;
        d = $urandom_range(15);
        if (d < 10) return 8'(8'h30 + d);
        if ($urandom_range(1)) return 8'(8'h61 + d - 10);
        return 8'(8'h41 + d - 10);
    endfunction

    function automatic logic [jsu8dec_pkg::BYTE_W-1:0] cont_byte();
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    function automatic void add_token();
        logic [jsu8dec_pkg::BYTE_W-1:0] c;
        int n;
        case ($urandom_range(9))
            0, 1, 2: begin
                c = 8'($urandom_range(127));
                if (c == jsu8dec_pkg::CH_QUOTE || c == jsu8dec_pkg::CH_BSLASH) c = 8'h7F;
                raw(c);
            end
            3: begin
                raw(jsu8dec_pkg::CH_BSLASH);
                case ($urandom_range(9))
                    0: raw(jsu8dec_pkg::CH_QUOTE);
                    1: raw(jsu8dec_pkg::CH_BSLASH);
                    2: raw(jsu8dec_pkg::CH_SLASH);
                    3: raw(jsu8dec_pkg::CH_LOW_B);
                    4: raw(jsu8dec_pkg::CH_LOW_F);
                    5: raw(jsu8dec_pkg::CH_LOW_N);
                    6: raw(jsu8dec_pkg::CH_LOW_R);
                    7: raw(jsu8dec_pkg::CH_LOW_T);
                    default: begin
                        c = 8'($urandom_range(255));
                        if (c == jsu8dec_pkg::CH_LOW_U) c = 8'hF5;
                        raw(c);
                    end
                endcase
            end
            4: begin
                raw(jsu8dec_pkg::CH_BSLASH);
                raw(jsu8dec_pkg::CH_LOW_U);
                repeat (4) begin
                    case ($urandom_range(11))
                        0: raw(jsu8dec_pkg::CH_QUOTE);
                        1: raw(8'($urandom_range(255)));
                        default: raw(hex_char());
                    endcase
                end
            end
            5: begin
                raw({3'b110, 5'($urandom_range(31))});
                raw(cont_byte());
            end
            6: begin
                raw({4'b1110, 4'($urandom_range(15))});
                repeat (2) raw(cont_byte());
            end
            7: begin
                raw({5'b11110, 3'($urandom_range(7))});
                repeat (3) raw(cont_byte());
            end
            8: begin
                if ($urandom_range(1)) raw(8'($urandom_range(8'h80, 8'hBF)));
                else raw(8'($urandom_range(8'hF8, 8'hFF)));
            end
            default: begin
                n = $urandom_range(1, 3);
                case (n)
                    1: raw({3'b110, 5'($urandom_range(31))});
                    2: raw({4'b1110, 4'($urandom_range(15))});
                    default: raw({5'b11110, 3'($urandom_range(7))});
                endcase
                repeat ($urandom_range(0, n - 1)) raw(cont_byte());
            end
        endcase
    endfunction

    function automatic void build_string();
        int kind;
        str_q.delete();
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 10))
                str_q.push_back('{8'($urandom_range(255)), ($urandom_range(7) == 0)});
        end else begin
            repeat ($urandom_range(1, 8)) add_token();
            if (kind < 80) begin
                raw(jsu8dec_pkg::CH_QUOTE);
            end else if (kind < 95) begin
                str_q[str_q.size()-1].be = 1'b1;
            end else begin
                str_q.push_back('{jsu8dec_pkg::CH_QUOTE, 1'b1});
            end
        end
    endfunction

    // stimulus
    initial begin
        int rand_sent;
        int str_idx;
        jsu8dec_pkg::t_result none;
        none = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.buffer_end = 1'b0;
        row_typed = 1'b0;
        row_res = '0;
        fail_cnt = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        clear_decoder();

        row(jsu8dec_pkg::CH_QUOTE,  1'b0, 1'b1, mk_close(1'b1, '0));
        row(8'h41,                  1'b0, 1'b1, mk_data(8'h41));
        row(jsu8dec_pkg::CH_BSLASH, 1'b0, 1'b0, none);
        row(jsu8dec_pkg::CH_LOW_N,  1'b0, 1'b1, mk_data(jsu8dec_pkg::CH_LF));
        row(jsu8dec_pkg::CH_BSLASH, 1'b0, 1'b0, none);
        row(jsu8dec_pkg::CH_QUOTE,  1'b0, 1'b1, mk_data(jsu8dec_pkg::CH_QUOTE));
        row(jsu8dec_pkg::CH_BSLASH, 1'b0, 1'b0, none);
        row(jsu8dec_pkg::CH_LOW_U,  1'b0, 1'b0, none);
        row(8'h31,                  1'b0, 1'b0, none);
        row(8'h30,                  1'b0, 1'b0, none);
        row(8'h46,                  1'b0, 1'b0, none);
        row(8'h67,                  1'b0, 1'b0, none);  // not a hex digit
        row(8'hC3,                  1'b0, 1'b0, none);
        row(8'hA9,                  1'b0, 1'b0, none);
        row(8'hE2,                  1'b0, 1'b0, none);
        row(8'h41,                  1'b0, 1'b0, none);  // breaks the sequence
        row(8'hFF,                  1'b0, 1'b1, mk_data(8'hFF));
        row(8'h00,                  1'b0, 1'b1, mk_data(8'h00));
        row(jsu8dec_pkg::CH_BSLASH, 1'b1, 1'b0, none);  // lone backslash at buffer end
        row(jsu8dec_pkg::CH_QUOTE,  1'b1, 1'b1, mk_close(1'b1, '0));
        row(8'hC3,                  1'b1, 1'b0, none);
        row(8'hE2,                  1'b0, 1'b0, none);
        row(8'h82,                  1'b0, 1'b0, none);
        row(jsu8dec_pkg::CH_QUOTE,  1'b0, 1'b0, none);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[k])
            send_byte(dir_table[k].b, dir_table[k].be, dir_table[k].typed, dir_table[k].res);

        rand_sent = 0;
        str_idx = 0;
        while (rand_sent < RAND_BYTES) begin
            if (str_idx == 0) quiet = 1'b1;
            if (str_idx == 2) quiet = 1'b0;
            if (str_idx == 4) drain_results();
            if (str_idx == 2) begin
                // plain run offered while the receiver holds off
                hold_req = 1'b1;
                str_q.delete();
                repeat (12) raw(8'($urandom_range(8'h30, 8'h5A)));
                raw(jsu8dec_pkg::CH_QUOTE);
            end else begin
                build_string();
            end
            rand_sent += str_q.size();
            foreach (str_q[k]) send_byte(str_q[k].b, str_q[k].be, 1'b0, none);
            str_idx++;
        end

        drain_results();
        repeat (10) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("json_string_utf8_byte_decoder test passed");
        end else begin
            $display("json_string_utf8_byte_decoder test failed");
        end
        $finish;
    end

endmodule
